>>> sv/crc32ra_pkg.sv
package crc32ra_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned LANES   = 4;
    localparam int unsigned BYTE_W  = 8;

    localparam logic [WORD_W-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [WORD_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
    localparam logic [WORD_W-1:0] CRC_XOUT = 32'hFFFF_FFFF;

    // bit of the control word that restarts the running CRC
    localparam int unsigned CTRL_INIT_BIT = 0;

    typedef enum logic {
        CMD_READ  = 1'b0,
        CMD_WRITE = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        REG_ID     = 2'd0,
        REG_CTRL   = 2'd1,
        REG_DATA   = 2'd2,
        REG_RESULT = 2'd3
    } reg_sel_t;

    typedef struct packed {
        cmd_t                     cmd;
        reg_sel_t                 reg_sel;
        logic [WORD_W-1:0]        write_word;
        logic [LANES-1:0]         lane_mask;
    } access_t;

    // fold one byte into the reflected CRC, one bit per step
    function automatic logic [WORD_W-1:0] crc32ra_fold_byte(
        input logic [WORD_W-1:0] crc,
        input logic [BYTE_W-1:0] data
    );
        logic [WORD_W-1:0] c;
        c = crc ^ {{(WORD_W-BYTE_W){1'b0}}, data};
        for (int k = 0; k < BYTE_W; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

>>> sv/crc32_register_accelerator.sv
// CRC-32/IEEE register engine on a stream interface. Each input item is one
// register access (kind, register select, write word, byte-lane mask) and
// gives exactly one output item, the read word: the ID constant, the final
// CRC (running CRC inverted), or zero for writes and for control and data
// reads. A control write with bit 0 set in an enabled lane 0 restarts the
// CRC at all ones; a data write folds its enabled lanes, lane 0 first, with
// the reflected polynomial 0xEDB88320. The block takes one item per clock
// cycle while the output is not stalled. Each item passes from the input
// register to the output register, which drives the read word. The rate
// is set by the CRC state loop: the running CRC register feeds a
// combinational four-lane byte fold. The input register holds the next
// item while a result waits in the output register, and a stalled output
// holds both.
module crc32_register_accelerator
    import crc32ra_pkg::*;
#(
    parameter logic [31:0] ID_CODE = 32'd1129464865
)
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // [31:0] write_word, [35:32] lane_mask, [39:36] zero
    input  logic [2:0]  s_axis_tuser,  // [0] cmd, [2:1] reg_sel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // [31:0] read_word
);

    access_t           in_access;
    access_t           stage_access;
    logic              stage_valid;
    logic              advance;
    logic              fire;

    logic [WORD_W-1:0] crc_reg;
    logic [WORD_W-1:0] crc_next;
    logic [WORD_W-1:0] crc_folded;
    logic [WORD_W-1:0] read_next;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [WORD_W-1:0] out_data_reg;

    // unpack the item; the upper tdata pad bits carry nothing
    assign in_access.cmd        = cmd_t'(s_axis_tuser[0]);
    assign in_access.reg_sel    = reg_sel_t'(s_axis_tuser[2:1]);
    assign in_access.write_word = s_axis_tdata[31:0];
    assign in_access.lane_mask  = s_axis_tdata[35:32];

    // move the staged item on whenever the output register is free or drains
    assign advance = !out_valid_reg || m_axis_tready;
    assign fire    = stage_valid && advance;

    crc32ra_in_reg u_in_reg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_axis_tvalid),
        .in_ready     (s_axis_tready),
        .in_access    (in_access),
        .advance      (advance),
        .stage_valid  (stage_valid),
        .stage_access (stage_access)
    );

    crc32ra_fold u_fold (
        .crc_in     (crc_reg),
        .write_word (stage_access.write_word),
        .lane_mask  (stage_access.lane_mask),
        .crc_out    (crc_folded)
    );

    // register decode: read word and CRC update for the staged item
    always_comb begin
        crc_next  = crc_reg;
        read_next = '0;
        case (stage_access.cmd)
            CMD_WRITE: begin
                case (stage_access.reg_sel)
                    REG_CTRL: begin
                        // init strobe counts only with lane 0 enabled
                        if (stage_access.lane_mask[0] &&
                            stage_access.write_word[CTRL_INIT_BIT]) begin
                            crc_next = CRC_INIT;
                        end
                    end
                    REG_DATA: begin
                        crc_next = crc_folded;
                    end
                    default: begin
                        // writes to ID and result are dropped
                        crc_next = crc_reg;
                    end
                endcase
            end
            CMD_READ: begin
                case (stage_access.reg_sel)
                    REG_ID:     read_next = ID_CODE;
                    REG_RESULT: read_next = crc_reg ^ CRC_XOUT;
                    default:    read_next = '0;
                endcase
            end
            default: begin
                read_next = '0;
            end
        endcase
    end

    assign out_valid_next = advance ? stage_valid : out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg       <= CRC_INIT;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            // commit the CRC only when the item leaves the stage
            if (fire) begin
                crc_reg <= crc_next;
            end
        end
        if (fire) begin
            out_data_reg <= read_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

>>> sv/crc32ra_in_reg.sv
module crc32ra_in_reg
    import crc32ra_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  access_t in_access,
    input  logic    advance,
    output logic    stage_valid,
    output access_t stage_access
);

    logic    valid_reg;
    logic    valid_next;
    access_t access_reg;

    // take a new item when empty or when the held one moves on this cycle
    assign in_ready   = !valid_reg || advance;
    assign valid_next = in_ready ? in_valid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (in_ready && in_valid) begin
            access_reg <= in_access;
        end
    end

    assign stage_valid  = valid_reg;
    assign stage_access = access_reg;

endmodule

>>> sv/crc32ra_fold.sv
module crc32ra_fold
    import crc32ra_pkg::*;
(
    input  logic [WORD_W-1:0] crc_in,
    input  logic [WORD_W-1:0] write_word,
    input  logic [LANES-1:0]  lane_mask,
    output logic [WORD_W-1:0] crc_out
);

    logic [WORD_W-1:0] chain [LANES+1];

    assign chain[0] = crc_in;

    // lane 0 first; a disabled lane passes the CRC through
    for (genvar i = 0; i < LANES; i++) begin : g_lane
        assign chain[i+1] = lane_mask[i]
            ? crc32ra_fold_byte(chain[i], write_word[BYTE_W*i +: BYTE_W])
            : chain[i];
    end

    assign crc_out = chain[LANES];

endmodule

>>> sv/crc32ra_checker.sv
module crc32ra_checker
    import crc32ra_pkg::*;
#(
    parameter logic [31:0] ID_CODE = 32'd1129464865
)
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [2:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata
);

    logic     s_acc;
    logic     acc_write;
    reg_sel_t acc_sel;

    assign s_acc     = s_axis_tvalid && s_axis_tready;
    assign acc_write = (cmd_t'(s_axis_tuser[0]) == CMD_WRITE);
    assign acc_sel   = reg_sel_t'(s_axis_tuser[2:1]);

    // hold a result until it is taken
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // a write, or a control or data read, returns zero
    a_zero_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && (acc_write || acc_sel == REG_CTRL ||
                   acc_sel == REG_DATA)) ##1 m_axis_tready
        |=> m_axis_tvalid && m_axis_tdata == 32'd0)
        else $error("nonzero read word for write or control/data read");

    // an ID read returns the build constant
    a_id_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && !acc_write && acc_sel == REG_ID) ##1 m_axis_tready
        |=> m_axis_tvalid && m_axis_tdata == ID_CODE)
        else $error("ID read returned wrong word");

endmodule

bind crc32_register_accelerator crc32ra_checker #(
    .ID_CODE (ID_CODE)
) u_crc32ra_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
